// ===== rtl/tllp_pkg.sv =====
// ----------------------------------------------------------------------------
// tllp_pkg: shared types and constants of the three-list link pool
// Slot encoding, sentinel slots, mode and status codes, and the command and
// status words passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tllp_pkg;

  // Pool geometry
  localparam int LINKS  = 64;
  localparam int IDX_W  = $clog2(LINKS);
  localparam int SLOT_W = $clog2(LINKS + 6);
  localparam int CNT_W  = $clog2(LINKS + 1);

  // Configuration register
  localparam int CFG_W            = 7;
  localparam int LINK_COUNT_RESET = 64;
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;
  localparam logic REG_LINK_COUNT = 1'b0;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Sentinel slots follow the entry slots
  localparam slot_t FREE_HEAD = SLOT_W'(LINKS + 0);
  localparam slot_t FREE_TAIL = SLOT_W'(LINKS + 1);
  localparam slot_t ONE_HEAD  = SLOT_W'(LINKS + 2);
  localparam slot_t ONE_TAIL  = SLOT_W'(LINKS + 3);
  localparam slot_t TWO_HEAD  = SLOT_W'(LINKS + 4);
  localparam slot_t TWO_TAIL  = SLOT_W'(LINKS + 5);

  typedef enum logic [1:0] {
    MODE_INIT      = 2'd0,
    MODE_ALLOC_ONE = 2'd1,
    MODE_ALLOC_TWO = 2'd2,
    MODE_MOVE      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch the word, read the entry, start init
    logic init_step;  // write one free-list entry
    logic unlink;     // splice the entry out of its list
    logic push_link;  // link entry after the target head
    logic push_prev;  // point entry back at the target head
    logic load_out;   // copy the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fail;       // request at the input cannot be served
    logic init_done;  // init walk has placed every entry
  } sts_t;

endpackage

// ===== rtl/tllp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tllp_ctrl: sequencer of the three-list link pool
// One-hot state machine that steps each word through init, unlink and push,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module tllp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    mode_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tllp_pkg::cmd_t cmd_o,
  input  tllp_pkg::sts_t sts_i
);
  import tllp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_INIT      = 6'b000010,
    ST_UNLINK    = 6'b000100,
    ST_PUSH_LINK = 6'b001000,
    ST_PUSH_PREV = 6'b010000,
    ST_DONE      = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Sequence the steps of one word
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (mode_i == MODE_INIT) begin
            state_d = ST_INIT;
          end else if (sts_i.fail) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_UNLINK;
          end
        end
      end
      ST_INIT: begin
        if (sts_i.init_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.init_step = 1'b1;
        end
      end
      ST_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = ST_PUSH_LINK;
      end
      ST_PUSH_LINK: begin
        cmd_o.push_link = 1'b1;
        state_d         = ST_PUSH_PREV;
      end
      ST_PUSH_PREV: begin
        cmd_o.push_prev = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new result shows up only out of the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done state");

  // Unlink is always followed by both push steps
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNLINK) |=> (state_q == ST_PUSH_LINK) ##1 (state_q == ST_PUSH_PREV))
    else $error("push steps skipped after unlink");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.load_out)
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/tllp_dpath.sv =====
// ----------------------------------------------------------------------------
// tllp_dpath: link tables and sentinels of the three-list link pool
// Next and prev entry memories, sentinel registers, pool count, init walk
// counter and the result registers.
// ----------------------------------------------------------------------------
module tllp_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tllp_pkg::cmd_t                  cmd_i,
  output tllp_pkg::sts_t                  sts_o,
  input  logic [1:0]                      mode_i,
  input  logic [tllp_pkg::IDX_W-1:0]      link_index_i,
  input  logic [tllp_pkg::CFG_W-1:0]      link_count_i,
  output logic [tllp_pkg::IDX_W-1:0]      result_index_o,
  output logic [1:0]                      status_o
);
  import tllp_pkg::*;

  // Entry memories
  slot_t next_mem [LINKS];
  slot_t prev_mem [LINKS];

  // Sentinel links: heads keep next, tails keep prev
  slot_t free_hn_q, free_hn_d, one_hn_q, one_hn_d, two_hn_q, two_hn_d;
  slot_t free_tp_q, free_tp_d, one_tp_q, one_tp_d, two_tp_q, two_tp_d;

  cnt_t    pool_q, cnt_q;
  idx_t    entry_q;
  logic    to_two_q;
  slot_t   rd_next_q, rd_prev_q;
  idx_t    res_q;
  status_e st_q;
  idx_t    out_idx_q;
  status_e out_st_q;

  cnt_t    init_cnt;
  logic    is_init, alloc_empty, move_range;
  idx_t    entry_sel;
  slot_t   first, head_slot, entry_slot;

  logic    nx_we, pv_we;
  idx_t    nx_addr, pv_addr;
  slot_t   nx_data, pv_data;

  function automatic logic is_entry(slot_t s);
    return s < SLOT_W'(LINKS);
  endfunction

  // Decode the word at the input
  assign init_cnt    = (32'(link_count_i) > LINKS) ? CNT_W'(LINKS) : CNT_W'(link_count_i);
  assign is_init     = (mode_i == MODE_INIT);
  assign alloc_empty = (free_hn_q == FREE_TAIL);
  assign move_range  = (CNT_W'(link_index_i) >= pool_q);
  assign entry_sel   = (mode_i == MODE_MOVE) ? link_index_i : free_hn_q[IDX_W-1:0];

  assign sts_o.fail      = (mode_i == MODE_MOVE) ? move_range : alloc_empty;
  assign sts_o.init_done = (cnt_q == pool_q);

  assign first      = to_two_q ? two_hn_q : one_hn_q;
  assign head_slot  = to_two_q ? TWO_HEAD : ONE_HEAD;
  assign entry_slot = SLOT_W'(entry_q);

  // Select the single write of each memory
  always_comb begin
    nx_we   = 1'b0;
    nx_addr = '0;
    nx_data = '0;
    pv_we   = 1'b0;
    pv_addr = '0;
    pv_data = '0;
    if (cmd_i.init_step) begin
      nx_we   = 1'b1;
      nx_addr = cnt_q[IDX_W-1:0];
      nx_data = (cnt_q == '0) ? FREE_TAIL : SLOT_W'(cnt_q - 1'b1);
      pv_we   = 1'b1;
      pv_addr = cnt_q[IDX_W-1:0];
      pv_data = (cnt_q == pool_q - 1'b1) ? FREE_HEAD : SLOT_W'(cnt_q + 1'b1);
    end
    if (cmd_i.unlink) begin
      if (is_entry(rd_next_q)) begin
        pv_we   = 1'b1;
        pv_addr = rd_next_q[IDX_W-1:0];
        pv_data = rd_prev_q;
      end
      if (is_entry(rd_prev_q)) begin
        nx_we   = 1'b1;
        nx_addr = rd_prev_q[IDX_W-1:0];
        nx_data = rd_next_q;
      end
    end
    if (cmd_i.push_link) begin
      nx_we   = 1'b1;
      nx_addr = entry_q;
      nx_data = first;
      if (is_entry(first)) begin
        pv_we   = 1'b1;
        pv_addr = first[IDX_W-1:0];
        pv_data = entry_slot;
      end
    end
    if (cmd_i.push_prev) begin
      pv_we   = 1'b1;
      pv_addr = entry_q;
      pv_data = head_slot;
    end
  end

  // Update the sentinel links
  always_comb begin
    free_hn_d = free_hn_q;
    one_hn_d  = one_hn_q;
    two_hn_d  = two_hn_q;
    free_tp_d = free_tp_q;
    one_tp_d  = one_tp_q;
    two_tp_d  = two_tp_q;
    if (cmd_i.accept && is_init) begin
      one_hn_d  = ONE_TAIL;
      one_tp_d  = ONE_HEAD;
      two_hn_d  = TWO_TAIL;
      two_tp_d  = TWO_HEAD;
      free_hn_d = (init_cnt == '0) ? FREE_TAIL : SLOT_W'(init_cnt - 1'b1);
      free_tp_d = (init_cnt == '0) ? FREE_HEAD : '0;
    end
    if (cmd_i.unlink) begin
      case (rd_next_q)
        FREE_TAIL: free_tp_d = rd_prev_q;
        ONE_TAIL:  one_tp_d  = rd_prev_q;
        TWO_TAIL:  two_tp_d  = rd_prev_q;
        default:   ;
      endcase
      case (rd_prev_q)
        FREE_HEAD: free_hn_d = rd_next_q;
        ONE_HEAD:  one_hn_d  = rd_next_q;
        TWO_HEAD:  two_hn_d  = rd_next_q;
        default:   ;
      endcase
    end
    if (cmd_i.push_link) begin
      if (to_two_q) begin
        two_hn_d = entry_slot;
      end else begin
        one_hn_d = entry_slot;
      end
      case (first)
        ONE_TAIL: one_tp_d = entry_slot;
        TWO_TAIL: two_tp_d = entry_slot;
        default:  ;
      endcase
    end
  end

  // Control state: sentinels, pool count, init walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_hn_q <= FREE_TAIL;
      one_hn_q  <= ONE_TAIL;
      two_hn_q  <= TWO_TAIL;
      free_tp_q <= FREE_HEAD;
      one_tp_q  <= ONE_HEAD;
      two_tp_q  <= TWO_HEAD;
      pool_q    <= '0;
      cnt_q     <= '0;
    end else begin
      free_hn_q <= free_hn_d;
      one_hn_q  <= one_hn_d;
      two_hn_q  <= two_hn_d;
      free_tp_q <= free_tp_d;
      one_tp_q  <= one_tp_d;
      two_tp_q  <= two_tp_d;
      if (cmd_i.accept && is_init) begin
        pool_q <= init_cnt;
        cnt_q  <= '0;
      end else if (cmd_i.init_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_addr] <= nx_data;
    end
    if (pv_we) begin
      prev_mem[pv_addr] <= pv_data;
    end
    if (cmd_i.accept) begin
      rd_next_q <= next_mem[entry_sel];
      rd_prev_q <= prev_mem[entry_sel];
    end
  end

  // Latch the word and its result; load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      entry_q  <= entry_sel;
      to_two_q <= (mode_i != MODE_ALLOC_ONE);
      if (is_init) begin
        res_q <= '0;
        st_q  <= STATUS_OK;
      end else if (sts_o.fail) begin
        res_q <= '0;
        st_q  <= (mode_i == MODE_MOVE) ? STATUS_RANGE : STATUS_EMPTY;
      end else begin
        res_q <= entry_sel;
        st_q  <= STATUS_OK;
      end
    end
    if (cmd_i.load_out) begin
      out_idx_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  assign result_index_o = out_idx_q;
  assign status_o       = out_st_q;

  // The init walk never writes past the latched count
  a_init_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.init_step |-> (cnt_q < pool_q))
    else $error("init walk past pool count");

  // The latched pool count never exceeds the pool size
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_q <= CNT_W'(LINKS))
    else $error("pool count above pool size");

endmodule

// ===== rtl/three_list_link_pool.sv =====
// ----------------------------------------------------------------------------
// three_list_link_pool: pool of link entries kept in three linked lists
// Free list, list one and list two, linked through next/prev index tables.
// Init fills the free list, allocate moves the free front to list one or two,
// move relinks a named entry to the front of list two.
//
//   channel  | direction | handshake             | words
//   in       | sink      | in_valid_i/in_stall_o | mode_i, link_index_i
//   out      | source    | out_valid_o/out_stall_i | result_index_o, status_o
//   cfg      | APB slave | psel/penable/pready   | link_count at 0x0
//
// Allocate and move step from the accept, which reads the entry, through unlink
// and two push steps (each bound by the single write port of the next and prev
// memories) to the output load. Init steps from the accept through one entry
// written per cycle and a final count check to the output load.
// A failed request goes from the accept straight to the output load.
// One word is in flight at a time.
// Reset empties all three lists; entry slots hold nothing until an init.
// A stalled result holds the block in its done state until taken.
// ----------------------------------------------------------------------------
module three_list_link_pool (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [tllp_pkg::IDX_W-1:0]    link_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tllp_pkg::IDX_W-1:0]    result_index_o,
  output logic [1:0]                    status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tllp_pkg::APB_AW-1:0]   paddr,
  input  logic [tllp_pkg::APB_DW-1:0]   pwdata,
  output logic [tllp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import tllp_pkg::*;

  logic [CFG_W-1:0] link_count_q;
  logic             cfg_wr;
  logic             cfg_hit;
  cmd_t             cmd;
  sts_t             sts;

  // Decode the register port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_AW-1:2] == REG_LINK_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_count_q <= CFG_W'(LINK_COUNT_RESET);
    end else if (cfg_wr) begin
      link_count_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = APB_DW'(link_count_q);
    end
  end

  tllp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tllp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .link_index_i   (link_index_i),
    .link_count_i   (link_count_q),
    .result_index_o (result_index_o),
    .status_o       (status_o)
  );

endmodule

// ===== tb/sv/link_pool_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_pool_checker: result predictor and comparator for the link pool
// Watches the input, output and register channels of three_list_link_pool.
// Tracks the link_count register and its own copy of the next/prev tables,
// works out the reply to every accepted word, and compares each accepted
// reply field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module link_pool_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  tllp_pkg::idx_t                link_index_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  tllp_pkg::idx_t                result_index_o,
  input  logic [1:0]                    status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tllp_pkg::APB_AW-1:0]   paddr,
  input  logic [tllp_pkg::APB_DW-1:0]   pwdata,
  input  logic [tllp_pkg::APB_DW-1:0]   prdata,
  input  logic                          pready,
  output int                            mismatch_count,
  output int                            replies_due,
  output int                            replies_seen
);
  import tllp_pkg::*;

  typedef struct packed {
    idx_t    index;
    status_e status;
  } pool_reply_t;

  // Shadow copy of the link tables and the register
  slot_t            next_slot [LINKS+6];
  slot_t            prev_slot [LINKS+6];
  cnt_t             pool_count;
  logic [CFG_W-1:0] link_count;
  pool_reply_t      pending_replies [$];

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic clear_lists();
    next_slot[FREE_HEAD] = FREE_TAIL;
    prev_slot[FREE_TAIL] = FREE_HEAD;
    next_slot[ONE_HEAD]  = ONE_TAIL;
    prev_slot[ONE_TAIL]  = ONE_HEAD;
    next_slot[TWO_HEAD]  = TWO_TAIL;
    prev_slot[TWO_TAIL]  = TWO_HEAD;
  endtask

  // Splice an entry out of whatever list holds it
  task automatic unlink_slot(input slot_t e);
    slot_t n;
    slot_t p;
    n = next_slot[e];
    p = prev_slot[e];
    prev_slot[n] = p;
    next_slot[p] = n;
  endtask

  // Link an entry right after a head sentinel
  task automatic push_after(input slot_t head, input slot_t e);
    slot_t first;
    first = next_slot[head];
    next_slot[e]     = first;
    prev_slot[first] = e;
    prev_slot[e]     = head;
    next_slot[head]  = e;
  endtask

  task automatic predict_pool_reply(input mode_e m, input idx_t idx, output pool_reply_t r);
    cnt_t  fill;
    slot_t e;
    r.index  = '0;
    r.status = STATUS_OK;
    case (m)
      MODE_INIT: begin
        // Saturate the count to the pool size, then refill the free list
        fill = (link_count > LINKS) ? cnt_t'(LINKS) : cnt_t'(link_count);
        clear_lists();
        for (int k = 0; k < fill; k++) push_after(FREE_HEAD, slot_t'(k));
        pool_count = fill;
      end
      MODE_ALLOC_ONE, MODE_ALLOC_TWO: begin
        e = next_slot[FREE_HEAD];
        if (e == FREE_TAIL) begin
          r.status = STATUS_EMPTY;
        end else begin
          unlink_slot(e);
          push_after((m == MODE_ALLOC_ONE) ? ONE_HEAD : TWO_HEAD, e);
          r.index = idx_t'(e);
        end
      end
      default: begin
        // Range check uses the count latched at the last init
        if (idx >= pool_count) begin
          r.status = STATUS_RANGE;
        end else begin
          unlink_slot(slot_t'(idx));
          push_after(TWO_HEAD, slot_t'(idx));
          r.index = idx;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_reply_t want;
    if (!rst_ni) begin
      clear_lists();
      pool_count     = '0;
      link_count     = CFG_W'(LINK_COUNT_RESET);
      pending_replies.delete();
      mismatch_count = 0;
      replies_due    = 0;
      replies_seen   = 0;
    end else begin
      // Track register writes, check register reads
      if (psel && penable && pready && paddr[APB_AW-1:2] == REG_LINK_COUNT) begin
        if (pwrite) begin
          link_count = pwdata[CFG_W-1:0];
        end else if (prdata !== APB_DW'(link_count)) begin
          note_mismatch($sformatf("link_count read: expected %0d, got %0h",
                                  link_count, prdata));
        end
      end
      // Predict the reply to each accepted word
      if (in_valid_i && !in_stall_o) begin
        predict_pool_reply(mode_e'(mode_i), link_index_i, want);
        pending_replies.push_back(want);
      end
      // Compare each accepted reply with the oldest prediction
      if (out_valid_o && !out_stall_i) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          note_mismatch($sformatf("unexpected reply: result_index %0d, status %0d",
                                  result_index_o, status_o));
        end else begin
          want = pending_replies.pop_front();
          if (result_index_o !== want.index || status_o !== want.status) begin
            note_mismatch($sformatf(
              "reply %0d: expected result_index %0d status %s, got %0d status %0d",
              replies_seen, want.index, want.status.name(), result_index_o, status_o));
          end
        end
      end
      replies_due = pending_replies.size();
    end
  end

endmodule

// ===== tb/sv/three_list_link_pool_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_list_link_pool_tb: stimulus and verdict for the three-list link pool
// Drives a directed opening (operations before any init, range and empty
// cases, moves of free entries, register edge values) and then phases of
// random init, allocate and move words under four idle profiles, with a long
// receiver hold and sender pauses. The checker does all prediction.
// ----------------------------------------------------------------------------
module three_list_link_pool_tb;
  import tllp_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 130;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [APB_AW-1:0] ADDR_LINK_COUNT = {REG_LINK_COUNT, 2'b00};
  // First address past the register list
  localparam logic [APB_AW-1:0] ADDR_UNUSED     = {1'b1, 2'b00};

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        mode_i;
  idx_t              link_index_i;
  logic              out_valid_o;
  logic              out_stall_i;
  idx_t              result_index_o;
  logic [1:0]        status_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int replies_due;
  int replies_seen;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int link_setting = LINK_COUNT_RESET;
  int pool_size    = 0;
  int words_sent   = 0;
  int inits_sent   = 0;

  three_list_link_pool dut (.*);

  link_pool_checker checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stall, or a long hold when one is requested
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one word after a random gap, return at the edge that takes it
  task automatic send_word(input mode_e m, input idx_t idx);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    link_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (m == MODE_INIT) begin
      inits_sent++;
      pool_size = (link_setting > LINKS) ? LINKS : link_setting;
    end
  endtask

  // Hold the sender until every reply is back, then let the block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (replies_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_link_count(input int value);
    wait_drained();
    cfg_access(1'b1, ADDR_LINK_COUNT, APB_DW'(value));
    cfg_access(1'b0, ADDR_LINK_COUNT, '0);
    link_setting = value;
  endtask

  initial begin
    int    pick;
    int    cnt;
    idx_t  idx;
    mode_e m;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_INIT;
    link_index_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Operations before any init: range flag and empty free list
    send_word(MODE_MOVE, '0);
    send_word(MODE_MOVE, '1);
    send_word(MODE_ALLOC_ONE, '0);
    send_word(MODE_ALLOC_TWO, '1);

    // Small pool: allocate, move a free entry, run dry, move within lists
    set_link_count(3);
    send_word(MODE_INIT, '0);
    send_word(MODE_ALLOC_ONE, '0);
    send_word(MODE_ALLOC_TWO, '0);
    send_word(MODE_MOVE, idx_t'(0));
    send_word(MODE_ALLOC_ONE, '1);
    send_word(MODE_MOVE, idx_t'(2));
    send_word(MODE_MOVE, idx_t'(1));
    send_word(MODE_MOVE, idx_t'(3));
    send_word(MODE_MOVE, '1);

    // Write past the register list, then saturate the count
    wait_drained();
    cfg_access(1'b1, ADDR_UNUSED, $urandom);
    cfg_access(1'b0, ADDR_LINK_COUNT, '0);
    set_link_count(127);
    send_word(MODE_INIT, '1);
    send_word(MODE_ALLOC_ONE, '0);
    send_word(MODE_MOVE, '1);
    send_word(MODE_ALLOC_TWO, '0);

    // Register change only lands at the next init
    set_link_count(5);
    send_word(MODE_MOVE, idx_t'(40));
    send_word(MODE_INIT, '0);
    send_word(MODE_MOVE, idx_t'(5));
    send_word(MODE_ALLOC_TWO, '0);

    // Empty pool after an init with zero entries
    set_link_count(0);
    send_word(MODE_INIT, '0);
    send_word(MODE_ALLOC_ONE, '0);
    send_word(MODE_MOVE, '0);

    // Random phases over the idle profiles
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(9))
        0:       cnt = 0;
        1:       cnt = 127;
        2:       cnt = LINKS;
        3:       cnt = $urandom_range(65, 126);
        default: cnt = $urandom_range(1, 16);
      endcase
      if (phase == 0) cnt = LINKS;
      set_link_count(cnt);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      send_word(MODE_INIT, idx_t'($urandom));
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (phase % 4 == 2 && w == 10) hold_token++;
        if (w == PHASE_WORDS / 2) wait_drained();
        pick = $urandom_range(99);
        idx  = idx_t'($urandom);
        if (pick < 4) begin
          m = MODE_INIT;
        end else if (pick < 34) begin
          m = MODE_ALLOC_ONE;
        end else if (pick < 64) begin
          m = MODE_ALLOC_TWO;
        end else begin
          m = MODE_MOVE;
          // Mostly valid indexes, some past the pool
          if (pool_size > 0 && $urandom_range(99) < 80)
            idx = idx_t'($urandom_range(pool_size - 1));
        end
        send_word(m, idx);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words (%0d inits) over %0d phases and four idle profiles;",
             words_sent, inits_sent, PHASES);
    $display("checked %0d replies with link counts from 0 to 127.", replies_seen);
    if (mismatch_count == 0 && replies_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
